### src/qpc_pkg.sv
// qpc_pkg: shared types and constants for the queen placement counter.
// No dependencies; used by the channel interfaces and the top level.
package qpc_pkg;

  localparam int FIELD_W = 5;
  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Search sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_STEP    = 5'b00010,
    S_POP     = 5'b00100,
    S_RESTORE = 5'b01000,
    S_DONE    = 5'b10000
  } qpc_state_t;

endpackage

### src/qpc_if.sv
// qpc_if: valid/ready channel interfaces for board items and count results.
// Depends on qpc_pkg for field widths.
interface qpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [qpc_pkg::FIELD_W-1:0]  board_rows;
  logic [qpc_pkg::FIELD_W-1:0]  board_cols;

  modport source (output valid, output board_rows, output board_cols, input ready);
  modport sink   (input valid, input board_rows, input board_cols, output ready);
endinterface

interface qpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [qpc_pkg::COUNT_W-1:0]  placement_count;

  modport source (output valid, output placement_count, input ready);
  modport sink   (input valid, input placement_count, output ready);
endinterface

### src/queen_placement_counter.sv
// queen_placement_counter: one item in, one placement count out, by backtracking.
// A rejected or zero-row board goes straight to the done state; else the search tries
// each candidate, backtracks through the pop and restore states, ends at an empty mask
// at row 0, then loads the output register once it is free. One item is searched at a time; the output
// register lets the next item enter while a count waits. Uses qpc_pkg and qpc_if.sv.
// Reset (rst_n, synchronous, active low) idles the sequencer and drops out valid.
module queen_placement_counter #(
  parameter int MAX_SIZE = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  qpc_in_if.sink          in_ch,
  qpc_out_if.source       out_ch
);

  localparam int IDX_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DIAG_N  = 2 * MAX_SIZE - 1;
  localparam int DIAG_IW = (MAX_SIZE > 1) ? $clog2(DIAG_N) : 1;
  localparam int MW1     = MAX_SIZE + 1;
  localparam int CW      = qpc_pkg::COUNT_W;
  localparam int FW      = qpc_pkg::FIELD_W;

  qpc_pkg::qpc_state_t state_r, state_nxt;

  logic [IDX_W-1:0]     d_r, d_nxt;
  logic [MAX_SIZE-1:0]  cand_r, cand_nxt;
  logic [MAX_SIZE-1:0]  full_r, full_nxt;
  logic [MAX_SIZE-1:0]  col_busy_r, col_busy_nxt;
  logic [DIAG_N-1:0]    sum_busy_r, sum_busy_nxt;
  logic [DIAG_N-1:0]    diff_busy_r, diff_busy_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [FW-1:0]        rows_r, rows_nxt;
  logic [FW-1:0]        cols_r, cols_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW-1:0]        out_count_r, out_count_nxt;

  // Backtrack stack: untried candidates and chosen column per row
  logic [MAX_SIZE-1:0]  cand_mem [MAX_SIZE];
  logic [IDX_W-1:0]     chosen_mem [MAX_SIZE];
  logic [MAX_SIZE-1:0]  rd_cand_r;
  logic [IDX_W-1:0]     rd_chosen_r;
  logic                 mem_we;
  logic [MAX_SIZE-1:0]  cand_push;

  logic [IDX_W-1:0]     low_c;
  logic [IDX_W-1:0]     c_sel;
  logic [5:0]           sum_idx6;
  logic [5:0]           diff_idx6;
  logic [MAX_SIZE-1:0]  one_m;
  logic [DIAG_N-1:0]    one_d;
  logic [MAX_SIZE-1:0]  cb;
  logic [DIAG_N-1:0]    sb;
  logic [DIAG_N-1:0]    db;
  logic                 conflict;
  logic                 last_row;
  logic                 in_acc;
  logic                 bad_board;
  logic [MW1-1:0]       full_wide;

  assign one_m = MAX_SIZE'(1);
  assign one_d = DIAG_N'(1);

  // Lowest set bit of the current candidate mask
  always_comb begin
    low_c = '0;
    for (int i = MAX_SIZE - 1; i >= 0; i--) begin
      if (cand_r[i]) low_c = IDX_W'(i);
    end
  end

  // Shared placement unit: same row index d_r whether placing or lifting a queen
  assign c_sel     = (state_r == qpc_pkg::S_RESTORE) ? rd_chosen_r : low_c;
  assign sum_idx6  = 6'(d_r) + 6'(c_sel);
  assign diff_idx6 = 6'(d_r) + 6'(cols_r) - 6'd1 - 6'(c_sel);
  assign cb        = one_m << c_sel;
  assign sb        = one_d << DIAG_IW'(sum_idx6);
  assign db        = one_d << DIAG_IW'(diff_idx6);
  assign conflict  = (|(col_busy_r & cb)) | (|(sum_busy_r & sb)) | (|(diff_busy_r & db));
  assign last_row  = (5'(d_r) + 5'd1) == rows_r;
  assign cand_push = cand_r & ~cb;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign bad_board = (6'(in_ch.board_rows) > 6'(MAX_SIZE)) ||
                     (6'(in_ch.board_cols) > 6'(MAX_SIZE)) ||
                     (in_ch.board_rows > in_ch.board_cols);
  assign full_wide = (MW1'(1) << in_ch.board_cols) - MW1'(1);

  assign in_ch.ready            = (state_r == qpc_pkg::S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.placement_count = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    cand_nxt      = cand_r;
    full_nxt      = full_r;
    col_busy_nxt  = col_busy_r;
    sum_busy_nxt  = sum_busy_r;
    diff_busy_nxt = diff_busy_r;
    count_nxt     = count_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    mem_we        = 1'b0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      qpc_pkg::S_IDLE: begin
        if (in_acc) begin
          rows_nxt      = in_ch.board_rows;
          cols_nxt      = in_ch.board_cols;
          full_nxt      = MAX_SIZE'(full_wide);
          cand_nxt      = MAX_SIZE'(full_wide);
          d_nxt         = '0;
          col_busy_nxt  = '0;
          sum_busy_nxt  = '0;
          diff_busy_nxt = '0;
          count_nxt     = '0;
          if (bad_board) begin
            state_nxt = qpc_pkg::S_DONE;
          end else if (in_ch.board_rows == '0) begin
            count_nxt = CW'(1);
            state_nxt = qpc_pkg::S_DONE;
          end else begin
            state_nxt = qpc_pkg::S_STEP;
          end
        end
      end
      qpc_pkg::S_STEP: begin
        if (cand_r == '0) begin
          if (d_r == '0) begin
            state_nxt = qpc_pkg::S_DONE;
          end else begin
            d_nxt     = d_r - IDX_W'(1);
            state_nxt = qpc_pkg::S_POP;
          end
        end else begin
          cand_nxt = cand_push;
          if (!conflict) begin
            if (last_row) begin
              if (count_r != qpc_pkg::COUNT_MAX) count_nxt = count_r + CW'(1);
            end else begin
              mem_we        = 1'b1;
              col_busy_nxt  = col_busy_r | cb;
              sum_busy_nxt  = sum_busy_r | sb;
              diff_busy_nxt = diff_busy_r | db;
              d_nxt         = d_r + IDX_W'(1);
              cand_nxt      = full_r;
            end
          end
        end
      end
      qpc_pkg::S_POP: begin
        // stack read at the parent row is in flight
        state_nxt = qpc_pkg::S_RESTORE;
      end
      qpc_pkg::S_RESTORE: begin
        cand_nxt      = rd_cand_r;
        col_busy_nxt  = col_busy_r & ~cb;
        sum_busy_nxt  = sum_busy_r & ~sb;
        diff_busy_nxt = diff_busy_r & ~db;
        state_nxt     = qpc_pkg::S_STEP;
      end
      qpc_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          state_nxt     = qpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = qpc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qpc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r         <= d_nxt;
    cand_r      <= cand_nxt;
    full_r      <= full_nxt;
    col_busy_r  <= col_busy_nxt;
    sum_busy_r  <= sum_busy_nxt;
    diff_busy_r <= diff_busy_nxt;
    count_r     <= count_nxt;
    rows_r      <= rows_nxt;
    cols_r      <= cols_nxt;
    out_count_r <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    rd_cand_r   <= cand_mem[d_r];
    rd_chosen_r <= chosen_mem[d_r];
    if (mem_we) begin
      cand_mem[d_r]   <= cand_push;
      chosen_mem[d_r] <= low_c;
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_depth_below_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qpc_pkg::S_STEP) |-> (5'(d_r) < rows_r))
    else $error("search depth reached row count");

  a_clear_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (col_busy_r == '0 && sum_busy_r == '0 && diff_busy_r == '0))
    else $error("busy masks not cleared at item start");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qpc_pkg::S_STEP && $past(state_r == qpc_pkg::S_STEP))
      |-> (count_r >= $past(count_r)))
    else $error("running count decreased during search");

endmodule

### test/tb_top.sv
// tb_top: self-checking bench for queen_placement_counter, board items in, counts out.
// Depends on qpc_pkg and the channel interfaces in src/qpc_if.sv.
`timescale 1ns / 100ps

module tb_top;

  localparam int BOARD_MAX = 16;
  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_BOARDS = 100;

  typedef struct packed {
    logic [qpc_pkg::FIELD_W-1:0] rows;
    logic [qpc_pkg::FIELD_W-1:0] cols;
  } board_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                        src_valid = 1'b0;
  logic [qpc_pkg::FIELD_W-1:0] src_rows = '0;
  logic [qpc_pkg::FIELD_W-1:0] src_cols = '0;
  logic                        sink_ready = 1'b0;

  board_t                      boards_pending[$];
  logic [qpc_pkg::COUNT_W-1:0] counts_due[$];
  board_t                      next_board;

  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  drive_jitter = 1'b1;
  bit  sink_jitter = 1'b1;
  int  boards_sent = 0;
  int  counts_checked = 0;
  int  mismatch_count = 0;
  int  idle_cycles = 0;

  qpc_in_if  board_ch ();
  qpc_out_if count_ch ();

  assign board_ch.valid      = src_valid;
  assign board_ch.board_rows = src_rows;
  assign board_ch.board_cols = src_cols;
  assign count_ch.ready      = sink_ready;

  queen_placement_counter #(.MAX_SIZE(BOARD_MAX)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (board_ch),
    .out_ch (count_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Places queens from row onward; masks carry the columns and diagonals in use.
  function automatic longint unsigned extend_rows(int row, int rows, int cols,
      logic [15:0] col_used, logic [31:0] sum_used, logic [31:0] diff_used);
    longint unsigned total;
    total = 0;
    if (row == rows) return 1;
    for (int c = 0; c < cols; c++) begin
      if (!col_used[c] && !sum_used[row + c] && !diff_used[row + cols - 1 - c])
        total += extend_rows(row + 1, rows, cols, col_used | (16'b1 << c),
                             sum_used | (32'b1 << (row + c)),
                             diff_used | (32'b1 << (row + cols - 1 - c)));
    end
    return total;
  endfunction

  function automatic logic [qpc_pkg::COUNT_W-1:0] expected_count(
      logic [qpc_pkg::FIELD_W-1:0] rows, logic [qpc_pkg::FIELD_W-1:0] cols);
    longint unsigned n;
    if (rows > BOARD_MAX || cols > BOARD_MAX || rows > cols) return '0;
    if (rows == 0) return qpc_pkg::COUNT_W'(1);
    n = extend_rows(0, rows, cols, '0, '0, '0);
    return (n > qpc_pkg::COUNT_MAX) ? qpc_pkg::COUNT_MAX : n[qpc_pkg::COUNT_W-1:0];
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_board(int rows, int cols);
    board_t b;
    b.rows = rows[qpc_pkg::FIELD_W-1:0];
    b.cols = cols[qpc_pkg::FIELD_W-1:0];
    boards_pending.push_back(b);
  endtask

  // Board driver
  always @(posedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && board_ch.ready) begin
        counts_due.push_back(expected_count(src_rows, src_cols));
        boards_sent++;
        if (boards_sent % 20 == 0) drive_jitter = ($urandom_range(0, 2) != 0);
        gap_left = drive_jitter ? pick_gap() : 0;
      end
      if (!src_valid || board_ch.ready) begin
        if (gap_left > 0 || boards_pending.size() == 0) begin
          if (gap_left > 0) gap_left--;
          src_valid <= 1'b0;
        end else begin
          next_board = boards_pending.pop_front();
          src_valid <= 1'b1;
          src_rows  <= next_board.rows;
          src_cols  <= next_board.cols;
        end
      end
    end
  end

  // Count monitor and receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (count_ch.valid && count_ch.ready) begin
        if (counts_due.size() == 0) begin
          $error("placement_count: expected none, actual %0d", count_ch.placement_count);
          mismatch_count++;
        end else if (counts_due[0] !== count_ch.placement_count) begin
          $error("placement_count: expected %0d, actual %0d",
                 counts_due[0], count_ch.placement_count);
          mismatch_count++;
          void'(counts_due.pop_front());
        end else begin
          void'(counts_due.pop_front());
        end
        counts_checked++;
        if (counts_checked % 25 == 0) sink_jitter = ($urandom_range(0, 2) != 0);
        // one long hold so the block backs up into its input
        if (counts_checked == 40 && !hold_done) begin
          hold_left = 500;
          hold_done = 1'b1;
        end
      end
      if (hold_left == 0 && stall_left == 0 && sink_jitter && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        sink_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((src_valid && board_ch.ready) || (count_ch.valid && count_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int pick;
    int r;
    int c;

    // directed boards: field extremes and the special cases
    add_board(0, 0);
    add_board(0, 16);
    add_board(0, 31);
    add_board(1, 1);
    add_board(2, 2);
    add_board(3, 3);
    add_board(4, 4);
    add_board(5, 5);
    add_board(6, 6);
    add_board(8, 8);
    add_board(3, 2);
    add_board(5, 0);
    add_board(16, 15);
    add_board(31, 31);
    add_board(17, 1);
    add_board(1, 16);
    add_board(2, 16);
    add_board(3, 16);
    add_board(1, 17);
    add_board(2, 5);
    add_board(3, 10);
    add_board(16, 0);

    for (int i = 0; i < RANDOM_BOARDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        c = $urandom_range(1, 7);
        r = $urandom_range(1, c);
      end else if (pick < 58) begin
        r = 0;
        c = $urandom_range(0, 31);
      end else if (pick < 68) begin
        // wide but shallow boards keep the search short
        c = $urandom_range(8, 16);
        r = $urandom_range(1, 3);
      end else if (pick < 72) begin
        c = 8;
        r = $urandom_range(6, 8);
      end else if (pick < 82) begin
        c = $urandom_range(0, 15);
        r = $urandom_range(c + 1, 31);
      end else if (pick < 91) begin
        r = $urandom_range(0, 31);
        c = $urandom_range(17, 31);
      end else begin
        r = $urandom_range(17, 31);
        c = $urandom_range(0, 31);
      end
      add_board(r, c);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (boards_pending.size() != 0 || src_valid || counts_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### queen_placement_counter.f
src/qpc_pkg.sv
src/qpc_if.sv
src/queen_placement_counter.sv
test/tb_top.sv
